/* hw/rtl/fpr2a_pkg.sv */
// Package for the fixed-point radix-to-ASCII converter.
// Types and constants shared by the front end, queue and back end. No dependencies.
package fpr2a_pkg;
  localparam int INT_W  = 32;
  localparam int FRAC_W = 32;
  localparam int MAX_PREC = 30;
  localparam int QDEPTH = 2;

  localparam logic [0:0] REG_BASE = 1'b0;
  localparam logic [0:0] REG_PREC = 1'b1;

  typedef struct packed {
    logic              neg;
    logic [INT_W-1:0]  ipart;
    logic [FRAC_W-1:0] frac;
    logic [5:0]        base;
    logic [4:0]        prec;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FRAC, S_ROUND, S_IDIV, S_EMIT
  } be_state_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [5:0] m;
    m = (d > 6'd35) ? d - 6'd36 : d;
    if (m < 6'd10) digit_char = 8'd48 + {2'b00, m};
    else digit_char = 8'd55 + {2'b00, m};
  endfunction
endpackage

/* hw/rtl/fpr2a_front.sv */
// Front end: accepts a request, clamps base and precision, and pushes a job into the queue.
// Depends on fpr2a_pkg.
module fpr2a_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [5:0]                cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_negative,
  input  logic [31:0]               in_int_magnitude,
  input  logic [31:0]               in_fraction,
  output logic                      q_valid,
  input  logic                      q_pop,
  output fpr2a_pkg::job_t           q_job
);
  import fpr2a_pkg::*;

  logic [5:0] base_r;
  logic [4:0] prec_r;
  job_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic [5:0] b_cl;
  logic [4:0] p_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 6'd10;
      prec_r <= 5'd2;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE) base_r <= cfg_data;
      else prec_r <= cfg_data[4:0];
    end
  end

  assign b_cl = (base_r < 6'd2) ? 6'd2 : ((base_r > 6'd36) ? 6'd36 : base_r);
  assign p_cl = (prec_r > 5'(MAX_PREC)) ? 5'(MAX_PREC) : prec_r;
  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{neg: in_negative, ipart: in_int_magnitude,
                               frac: in_fraction, base: b_cl, prec: p_cl};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

/* hw/rtl/fpr2a_back.sv */
// Back end: fraction digits by multiply, rounding, integer digits by serial division, emit.
// Depends on fpr2a_pkg.
module fpr2a_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  fpr2a_pkg::job_t  q_job,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);
  import fpr2a_pkg::*;

  be_state_t   st_r, st_nxt;
  job_t        job_r;
  logic [FRAC_W-1:0] f_r;
  logic [5:0]  fd_r [MAX_PREC];
  logic [5:0]  idig_r [INT_W];
  logic [4:0]  fi_r;      // fraction digit index
  logic [5:0]  k_r;       // integer digit count
  logic [INT_W-1:0] wv_r; // value being divided
  logic [INT_W-1:0] quo_r;
  logic [6:0]  rem_r;
  logic [5:0]  bit_r;
  logic [6:0]  pos_r;     // emit position
  logic [6:0]  cnt_r;     // emitted chars
  logic        carry_r;
  logic        rnd_r;

  logic [FRAC_W+5:0] prod;
  logic [6:0]  rem_sh;
  logic        ge;
  logic [6:0]  total;
  logic [7:0]  ch;
  logic        emit_fire;
  logic        lastc;
  logic [6:0]  o_neg, o_int, o_pt;

  assign prod = f_r * job_r.base;
  assign rem_sh = {rem_r[5:0], wv_r[INT_W-1]};
  assign ge = rem_sh >= {1'b0, job_r.base};

  // layout: [neg][k int digits][. + prec frac digits]
  assign o_neg = 7'(job_r.neg);
  assign o_int = o_neg + {1'b0, k_r};
  assign o_pt  = o_int;
  assign total = o_int + ((job_r.prec != 5'd0) ? 7'(job_r.prec) + 7'd1 : 7'd0);

  always_comb begin
    if (job_r.neg && pos_r == 7'd0) ch = 8'd45;
    else if (pos_r < o_int) ch = digit_char(idig_r[5'(o_int - 7'd1 - pos_r)]);
    else if (pos_r == o_pt) ch = 8'd46;
    else ch = digit_char(fd_r[5'(pos_r - o_pt - 7'd1)]);
  end
  assign lastc = (pos_r == total - 7'd1) || (cnt_r == 7'd63);
  assign out_valid = (st_r == S_EMIT);
  assign out_character = ch;
  assign out_last = lastc;
  assign emit_fire = out_valid && !out_stall;
  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = S_FRAC;
      S_FRAC:  if (fi_r == job_r.prec) st_nxt = S_ROUND;
      S_ROUND: if (!rnd_r || !carry_r || fi_r == 5'd0) st_nxt = S_IDIV;
      S_IDIV:  if (bit_r == 6'(INT_W) && (quo_r == '0 || k_r == 6'd63)) st_nxt = S_EMIT;
      S_EMIT:  if (emit_fire && lastc) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        job_r <= q_job;
        f_r <= q_job.frac;
        fi_r <= 5'd0;
        k_r <= 6'd0;
      end
      S_FRAC: begin
        if (fi_r != job_r.prec) begin
          fd_r[fi_r] <= prod[FRAC_W+5:FRAC_W];
          f_r <= prod[FRAC_W-1:0];
          fi_r <= fi_r + 5'd1;
        end else begin
          rnd_r <= (job_r.prec != 5'd0) && f_r[FRAC_W-1];
          carry_r <= 1'b1;
        end
      end
      S_ROUND: begin
        // ripple one digit per cycle from the last fraction digit
        if (rnd_r && carry_r && fi_r != 5'd0) begin
          if (fd_r[fi_r-5'd1] + 6'd1 < job_r.base) begin
            fd_r[fi_r-5'd1] <= fd_r[fi_r-5'd1] + 6'd1;
            carry_r <= 1'b0;
          end else fd_r[fi_r-5'd1] <= 6'd0;
          fi_r <= fi_r - 5'd1;
        end else begin
          if (rnd_r && carry_r) begin
            if (job_r.ipart != '1) job_r.ipart <= job_r.ipart + 1'b1;
            else for (int i = 0; i < MAX_PREC; i++) fd_r[i] <= job_r.base - 6'd1;
          end
          wv_r <= (rnd_r && carry_r && job_r.ipart != '1) ? job_r.ipart + 1'b1
                                                          : job_r.ipart;
          rem_r <= 7'd0;
          bit_r <= 6'd0;
          quo_r <= '0;
        end
      end
      S_IDIV: begin
        if (bit_r != 6'(INT_W)) begin
          rem_r <= ge ? rem_sh - {1'b0, job_r.base} : rem_sh;
          quo_r <= {quo_r[INT_W-2:0], ge};
          wv_r <= {wv_r[INT_W-2:0], 1'b0};
          bit_r <= bit_r + 6'd1;
        end else begin
          idig_r[k_r[4:0]] <= rem_r[5:0];
          k_r <= k_r + 6'd1;
          wv_r <= quo_r;
          quo_r <= '0;
          rem_r <= 7'd0;
          bit_r <= 6'd0;
          pos_r <= 7'd0;
          cnt_r <= 7'd0;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          pos_r <= pos_r + 7'd1;
          cnt_r <= cnt_r + 7'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

/* hw/rtl/fixed_point_radix_to_ascii.sv */
// Order: the back end pops a job, computes the fraction digits, ripples any rounding carry back
// through them and divides out the integer digits bit-serially before the first character;
// then one character per cycle while out_stall is low. The bit-serial divider sets the rate.
// Each number is fully emitted before the next is taken; a 2-entry queue decouples.
// Reset (rst_n low, synchronous) sets base 10, precision 2 and empties queue and back end.
// Top level: front end with queue, and back end. Depends on fpr2a_pkg, fpr2a_front, fpr2a_back.
module fixed_point_radix_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_negative,
  input  logic [31:0] in_int_magnitude,
  input  logic [31:0] in_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import fpr2a_pkg::*;

  logic q_valid, q_pop;
  job_t q_job;

  fpr2a_front u_front (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_negative, .in_int_magnitude, .in_fraction, .q_valid, .q_pop, .q_job);
  fpr2a_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_job, .out_valid, .out_stall,
    .out_character, .out_last);

`ifndef ASSERT_OFF
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character))
    else $error("result changed while stalled");
`endif
endmodule

/* dv/fixed_point_radix_to_ascii_test.sv */
// Testbench for fixed_point_radix_to_ascii: predicts the text of each number in
// SystemVerilog and checks every character. Depends on fpr2a_pkg and the RTL.
module fixed_point_radix_to_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpr2a_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_negative;
  logic [31:0] in_int_magnitude;
  logic [31:0] in_fraction;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_character;
  logic        out_last;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  char_t       text_q[$];
  logic [5:0]  cur_base;
  logic [4:0]  cur_prec;
  int          errors;
  int          cycles;
  bit          hold_off;
  int          hold_cycles;
  bit          rx_steady;
  bit          tx_steady;

  localparam int LIMIT = 4_000_000;

  fixed_point_radix_to_ascii i_dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] glyph(input int d);
    return (d < 10) ? 8'(48 + d) : 8'(55 + d);
  endfunction

  // Expected text of one number under the current settings.
  task automatic predict_text(input logic neg, input logic [31:0] ip_in,
                              input logic [31:0] fr_in);
    int         b;
    int         p;
    int         fd[31];
    int         rd[31];
    logic [63:0] f;
    logic [63:0] prod;
    logic [32:0] ip;
    logic [7:0] txt[$];
    int         idig[$];
    bit         carry;
    b = cur_base < 2 ? 2 : (cur_base > 36 ? 36 : cur_base);
    p = cur_prec > MAX_PREC ? MAX_PREC : cur_prec;
    f = {32'd0, fr_in};
    ip = {1'b0, ip_in};
    for (int i = 0; i < p; i++) begin
      prod = f * b;
      fd[i] = int'(prod[63:32]);
      f = {32'd0, prod[31:0]};
    end
    if (p > 0 && f[31]) begin
      carry = 1;
      rd = fd;
      for (int i = p - 1; i >= 0 && carry; i--) begin
        if (rd[i] + 1 < b) begin
          rd[i]++;
          carry = 0;
        end else
          rd[i] = 0;
      end
      if (!carry) fd = rd;
      else if (ip < 33'hFFFF_FFFF) begin
        fd = rd;
        ip++;
      end
    end
    do begin
      idig.push_front(int'(ip % b));
      ip = ip / b;
    end while (ip != 0);
    if (neg) txt.push_back("-");
    foreach (idig[i]) txt.push_back(glyph(idig[i]));
    if (p > 0) begin
      txt.push_back(".");
      for (int i = 0; i < p; i++) txt.push_back(glyph(fd[i]));
    end
    while (txt.size() > 64) void'(txt.pop_back());
    foreach (txt[i]) text_q.push_back('{txt[i], i == txt.size() - 1});
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0)
        report_mismatch($sformatf("unexpected char %h", out_character));
      else begin
        exp_c = text_q.pop_front();
        if (out_character !== exp_c.ch)
          report_mismatch($sformatf("char %h, expected %h", out_character, exp_c.ch));
        if (out_last !== exp_c.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, exp_c.last));
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // Receiver stall pattern; long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else if (rx_steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : (gap_len() > 20);
  end

  // Leaves in_valid high after the accepting edge; the next gap, drain or
  // back-to-back request decides what follows.
  task automatic send_request(input logic neg, input logic [31:0] ip,
                              input logic [31:0] fr);
    int g;
    g = tx_steady ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_negative <= neg;
    in_int_magnitude <= ip;
    in_fraction <= fr;
    predict_text(neg, ip, fr);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    int w;
    w = 0;
    in_valid <= 1'b0;
    while (text_q.size() != 0 && w < 200000) begin
      @(posedge clk);
      w++;
    end
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [5:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE) cur_base = val;
    else cur_prec = val[4:0];
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 100);
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_request(1'b0, 32'd0, 32'd0);
    send_request(1'b1, 32'd0, 32'd0);
    send_request(1'b0, 32'd4, 32'h8000_0000);
    send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'd9, 32'hFFFF_FFFF);
    drain();
    write_cfg(REG_BASE, 6'd2);
    write_cfg(REG_PREC, 6'd30);
    send_request(1'b0, 32'd4, 32'd0);
    send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'hFFFF_FFFF, 32'h5555_5555);
    drain();
    write_cfg(REG_BASE, 6'd36);
    write_cfg(REG_PREC, 6'd0);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd35, 32'd0);
    drain();
    write_cfg(REG_BASE, 6'd0);
    write_cfg(REG_PREC, 6'd31);
    send_request(1'b0, 32'd5, 32'h8000_0000);
    send_request(1'b1, 32'h1234_5678, 32'h9ABC_DEF0);
    drain();
    write_cfg(REG_BASE, 6'd63);
    write_cfg(REG_PREC, 6'd1);
    send_request(1'b0, 32'd1000, 32'hFF00_0000);
    send_request(1'b1, 32'hFFFF_FFFF, 32'hF000_0000);
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(REG_BASE, 6'($urandom_range(0, 63)));
      write_cfg(REG_PREC, ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 31))
                                                        : 6'($urandom_range(0, 6)));
      tx_steady = (ph % 4 == 3);
      rx_steady = (ph % 4 == 2);
      for (int n = 0; n < 28; n++)
        send_request(1'($urandom_range(0, 1)), rand_word(), rand_word());
      tx_steady = 0;
      rx_steady = 0;
      drain();
    end
  endtask

  // Receiver holds off long while the sender keeps offering, then the sender
  // pauses until every expected character has come, then sends four more and drains.
  task automatic test_backpressure();
    write_cfg(REG_BASE, 6'd10);
    write_cfg(REG_PREC, 6'd4);
    hold_off = 1;
    tx_steady = 1;
    fork
      for (int n = 0; n < 6; n++)
        send_request(1'($urandom_range(0, 1)), $urandom(), $urandom());
      wait (hold_cycles >= 2000);
    join_any
    wait (hold_cycles >= 2000);
    hold_off = 0;
    wait fork;
    tx_steady = 0;
    drain();
    for (int n = 0; n < 4; n++) send_request(1'b0, $urandom(), $urandom());
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    hold_cycles = 0;
    rx_steady = 0;
    tx_steady = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_negative = 1'b0;
    in_int_magnitude = '0;
    in_fraction = '0;
    cur_base = 6'd10;
    cur_prec = 5'd2;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    if (text_q.size() != 0)
      report_mismatch($sformatf("%0d characters never came", text_q.size()));
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/fpr2a_pkg.sv
hw/rtl/fpr2a_front.sv
hw/rtl/fpr2a_back.sv
hw/rtl/fixed_point_radix_to_ascii.sv
dv/fixed_point_radix_to_ascii_test.sv
